### hw/rtl/arw_pkg.sv
// arw_pkg: shared constants, codes and types for the anti-replay window block
// no dependencies; used by arw_window, anti_replay_window_top and arw_checker
`default_nettype none

package arw_pkg;

  localparam int CTR_W      = 64;
  localparam int LEN_W      = 16;
  localparam int VERDICT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // default bitmap depth, top level parameter default
  localparam int WINDOW_SIZE_DEF = 64;
  // shortest datagram that can hold header and tag
  localparam int MIN_LENGTH = 24;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OK          = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_SESSION  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_SHORT   = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_OVER_LIMIT  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD     = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_REPLAYED    = 3'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_AUTH_FAILED = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_OPEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT = 1'd1;

  // one datagram handed to the window for judging
  typedef struct packed {
    logic             valid;
    logic [CTR_W-1:0] counter;
    logic [LEN_W-1:0] length;
    logic             auth_ok;
  } arw_req_t;

endpackage

`default_nettype wire

### hw/rtl/arw_window.sv
// arw_window: window state (newest counter, seen bitmap) and the per-datagram judge
// depends on arw_pkg
`default_nettype none

module arw_window #(
  parameter int WINDOW_SIZE = arw_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clear,
  input  wire logic                         session_open,
  input  wire logic [arw_pkg::CTR_W-1:0]    message_limit,
  input  wire arw_pkg::arw_req_t            req,
  output logic      [arw_pkg::VERDICT_W-1:0] verdict
);

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [arw_pkg::CTR_W-1:0] WIN_LIM = arw_pkg::CTR_W'(WINDOW_SIZE);

  logic                      started_r, started_nxt;
  logic [arw_pkg::CTR_W-1:0] newest_r, newest_nxt;
  logic [WINDOW_SIZE-1:0]    seen_r, seen_nxt;

  logic                      behind;
  logic [arw_pkg::CTR_W-1:0] back_dist;
  logic [arw_pkg::CTR_W-1:0] fwd_dist;
  logic                      back_in_win;
  logic                      fwd_in_win;
  logic [IDX_W-1:0]          back_idx;
  logic [IDX_W-1:0]          fwd_idx;
  logic                      seen_hit;

  assign behind      = started_r && (req.counter <= newest_r);
  assign back_dist   = newest_r - req.counter;
  assign fwd_dist    = req.counter - newest_r;
  assign back_in_win = back_dist < WIN_LIM;
  assign fwd_in_win  = fwd_dist < WIN_LIM;
  assign back_idx    = back_dist[IDX_W-1:0];
  assign fwd_idx     = fwd_dist[IDX_W-1:0];
  // index only meaningful inside the window
  assign seen_hit    = back_in_win && seen_r[back_idx];

  always_comb begin
    if (!session_open) begin
      verdict = arw_pkg::VERDICT_NO_SESSION;
    end else if (req.length < arw_pkg::LEN_W'(arw_pkg::MIN_LENGTH)) begin
      verdict = arw_pkg::VERDICT_TOO_SHORT;
    end else if (req.counter >= message_limit) begin
      verdict = arw_pkg::VERDICT_OVER_LIMIT;
    end else if (behind && !back_in_win) begin
      verdict = arw_pkg::VERDICT_TOO_OLD;
    end else if (behind && seen_hit) begin
      verdict = arw_pkg::VERDICT_REPLAYED;
    end else if (!req.auth_ok) begin
      verdict = arw_pkg::VERDICT_AUTH_FAILED;
    end else begin
      verdict = arw_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    started_nxt = started_r;
    newest_nxt  = newest_r;
    seen_nxt    = seen_r;
    if (clear) begin
      started_nxt = 1'b0;
      newest_nxt  = '0;
      seen_nxt    = '0;
    end else if (req.valid && (verdict == arw_pkg::VERDICT_OK)) begin
      if (!started_r) begin
        started_nxt = 1'b1;
        newest_nxt  = req.counter;
        seen_nxt    = WINDOW_SIZE'(1);
      end else if (!behind) begin
        // counter ahead: slide the bitmap and mark the new newest
        newest_nxt = req.counter;
        seen_nxt   = fwd_in_win ? ((seen_r << fwd_idx) | WINDOW_SIZE'(1))
                                : WINDOW_SIZE'(1);
      end else begin
        seen_nxt = seen_r | (WINDOW_SIZE'(1) << back_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      newest_r  <= '0;
      seen_r    <= '0;
    end else begin
      started_r <= started_nxt;
      newest_r  <= newest_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/anti_replay_window_top.sv
// anti_replay_window_top: input register, window judge and result register
// depends on arw_pkg and arw_window
//
//   channel  | handshake                 | beat contents
//   ---------+---------------------------+--------------------------------------------
//   in       | in_valid / in_ready       | packet_counter, packet_length, auth_ok
//   out      | out_valid / out_ready     | accepted, verdict
//   cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// one beat per cycle sustained unless out stalls; beats pass input then result register
// window state updates at the edge the input register hands its beat to the
// result register, so the following beat always sees the updated window
// a stall on out holds the result register and then the input register
// reset: session closed, message_limit all ones, window empty
`default_nettype none

module anti_replay_window_top #(
  parameter int WINDOW_SIZE = arw_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [arw_pkg::CTR_W-1:0]       in_packet_counter,
  input  wire logic [arw_pkg::LEN_W-1:0]       in_packet_length,
  input  wire logic                            in_auth_ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_accepted,
  output logic      [arw_pkg::VERDICT_W-1:0]   out_verdict,
  input  wire logic                            cfg_we,
  input  wire logic [arw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [arw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                           session_open_r;
  logic [arw_pkg::CTR_W-1:0]      message_limit_r;

  logic                           s1_valid_r;
  logic [arw_pkg::CTR_W-1:0]      s1_counter_r;
  logic [arw_pkg::LEN_W-1:0]      s1_length_r;
  logic                           s1_auth_r;

  logic                           out_valid_r;
  logic                           out_accepted_r;
  logic [arw_pkg::VERDICT_W-1:0]  out_verdict_r;

  logic                           s1_adv;
  logic                           win_clear;
  arw_pkg::arw_req_t              win_req;
  logic [arw_pkg::VERDICT_W-1:0]  win_verdict;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign win_clear = cfg_we && (cfg_index == arw_pkg::REG_SESSION_OPEN);

  assign win_req.valid   = s1_adv;
  assign win_req.counter = s1_counter_r;
  assign win_req.length  = s1_length_r;
  assign win_req.auth_ok = s1_auth_r;

  arw_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear         (win_clear),
    .session_open  (session_open_r),
    .message_limit (message_limit_r),
    .req           (win_req),
    .verdict       (win_verdict)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_open_r  <= 1'b0;
      message_limit_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arw_pkg::REG_SESSION_OPEN:  session_open_r  <= cfg_data[0];
        arw_pkg::REG_MESSAGE_LIMIT: message_limit_r <= cfg_data[arw_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_counter_r <= in_packet_counter;
      s1_length_r  <= in_packet_length;
      s1_auth_r    <= in_auth_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_verdict_r  <= win_verdict;
      out_accepted_r <= (win_verdict == arw_pkg::VERDICT_OK);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;
  assign out_verdict  = out_verdict_r;

endmodule

`default_nettype wire

### hw/rtl/arw_checker.sv
// arw_checker: port-level assertions for anti_replay_window_top, attached by bind
// depends on arw_pkg
`default_nettype none

module arw_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            out_accepted,
  input wire logic [arw_pkg::VERDICT_W-1:0]   out_verdict
);

  // accepted flag agrees with the verdict code
  a_accept_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_verdict == arw_pkg::VERDICT_OK)))
    else $error("accepted flag disagrees with verdict");

  // only defined verdict codes leave the block
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict <= arw_pkg::VERDICT_AUTH_FAILED))
    else $error("undefined verdict code");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result beat present after reset");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_verdict)
                                   && $stable(out_accepted)))
    else $error("stalled result beat changed");

endmodule

bind anti_replay_window_top arw_checker u_arw_checker (.*);

`default_nettype wire
